### rtl/hrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrd_pkg
// Shared types, codes and character tables of the http response deframer.
// ----------------------------------------------------------------------------
package hrd_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 32;

  localparam logic [4:0] LEN_TAG = 5'd14;
  localparam logic [4:0] TE_TAG  = 5'd17;
  localparam logic [4:0] CHK_TAG = 5'd7;
  localparam logic [4:0] HTTP_TAG = 5'd5;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;

  localparam logic [2:0] KIND_CONTENT  = 3'd0;
  localparam logic [2:0] KIND_STATUS   = 3'd1;
  localparam logic [2:0] KIND_COMPLETE = 3'd2;
  localparam logic [2:0] KIND_BAD      = 3'd3;
  localparam logic [2:0] KIND_EARLY    = 3'd4;

  localparam logic [2:0] F_CR    = 3'b001;
  localparam logic [2:0] F_NEG   = 3'b010;
  localparam logic [2:0] F_TRAIL = 3'b100;

  typedef enum logic [3:0] {
    PH_PREFIX, PH_VER, PH_SP, PH_CODE, PH_REST,
    PH_NAME, PH_WS, PH_VAL, PH_BADLINE,
    PH_BODY, PH_TAIL, PH_CKSIZE, PH_CKDATA, PH_CKEND, PH_DONE
  } phase_t;

  function automatic logic [7:0] http_chr(input logic [2:0] idx);
    case (idx)
      3'd0: http_chr = 8'h48;
      3'd1: http_chr = 8'h54;
      3'd2: http_chr = 8'h54;
      3'd3: http_chr = 8'h50;
      3'd4: http_chr = 8'h2f;
      default: http_chr = 8'h00;
    endcase
  endfunction

  // "Content-Length"
  function automatic logic [7:0] len_chr(input logic [3:0] idx);
    case (idx)
      4'd0:  len_chr = 8'h43;
      4'd1:  len_chr = 8'h6f;
      4'd2:  len_chr = 8'h6e;
      4'd3:  len_chr = 8'h74;
      4'd4:  len_chr = 8'h65;
      4'd5:  len_chr = 8'h6e;
      4'd6:  len_chr = 8'h74;
      4'd7:  len_chr = 8'h2d;
      4'd8:  len_chr = 8'h4c;
      4'd9:  len_chr = 8'h65;
      4'd10: len_chr = 8'h6e;
      4'd11: len_chr = 8'h67;
      4'd12: len_chr = 8'h74;
      4'd13: len_chr = 8'h68;
      default: len_chr = 8'h00;
    endcase
  endfunction

  // "Transfer-Encoding"
  function automatic logic [7:0] te_chr(input logic [4:0] idx);
    case (idx)
      5'd0:  te_chr = 8'h54;
      5'd1:  te_chr = 8'h72;
      5'd2:  te_chr = 8'h61;
      5'd3:  te_chr = 8'h6e;
      5'd4:  te_chr = 8'h73;
      5'd5:  te_chr = 8'h66;
      5'd6:  te_chr = 8'h65;
      5'd7:  te_chr = 8'h72;
      5'd8:  te_chr = 8'h2d;
      5'd9:  te_chr = 8'h45;
      5'd10: te_chr = 8'h6e;
      5'd11: te_chr = 8'h63;
      5'd12: te_chr = 8'h6f;
      5'd13: te_chr = 8'h64;
      5'd14: te_chr = 8'h69;
      5'd15: te_chr = 8'h6e;
      5'd16: te_chr = 8'h67;
      default: te_chr = 8'h00;
    endcase
  endfunction

  // "chunked"
  function automatic logic [7:0] chk_chr(input logic [2:0] idx);
    case (idx)
      3'd0: chk_chr = 8'h63;
      3'd1: chk_chr = 8'h68;
      3'd2: chk_chr = 8'h75;
      3'd3: chk_chr = 8'h6e;
      3'd4: chk_chr = 8'h6b;
      3'd5: chk_chr = 8'h65;
      3'd6: chk_chr = 8'h64;
      default: chk_chr = 8'h00;
    endcase
  endfunction

  // bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) hex_dec = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      hex_dec = {1'b1, c[3:0] + 4'd9};
    else hex_dec = 5'd0;
  endfunction

endpackage
`default_nettype wire

### rtl/http_response_deframer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// the result of an accepted item is registered in the output register
// one byte per cycle unless stalled; the parser state is updated in the accept cycle
// an item is taken while a result waits, as long as that result is taken too
// reset (synchronous, rst_n low) returns to the start of the status line
// and clears the no-body flag; after a final result all items are dropped until reset
// ----------------------------------------------------------------------------
// http_response_deframer_unit
// Byte-serial HTTP/1.1 response parser with counted and chunked body decoding.
// ----------------------------------------------------------------------------
module http_response_deframer_unit
  import hrd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_no_body,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte_in,
  input  wire logic        in_stream_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [31:0]      out_value
);

  localparam int unsigned LB = LENGTH_BITS;
  localparam logic [LB-1:0] LEN_MAX = '1;
  localparam logic [LB-1:0] LEN_ONE = {{(LB-1){1'b0}}, 1'b1};

  typedef struct packed {
    phase_t        phase;
    logic [4:0]    mpos;
    logic [1:0]    cand;
    logic [2:0]    flags;
    logic [15:0]   status;
    logic [LB-1:0] decl;
    logic          len_present;
    logic          chunked;
    logic [LB-1:0] remain;
    logic [LB-1:0] total;
  } st_t;

  typedef struct packed {
    st_t         st;
    logic        emit;
    logic [2:0]  kind;
    logic [31:0] value;
  } step_t;

  function automatic logic [LB-1:0] mac10(input logic [LB-1:0] acc, input logic [3:0] d);
    logic [LB+3:0] a;
    logic [LB+3:0] w;
    a = {4'b0, acc};
    w = (a << 3) + (a << 1) + {{LB{1'b0}}, d};
    if (w[LB+3:LB] != 4'd0) mac10 = LEN_MAX;
    else mac10 = w[LB-1:0];
  endfunction

  function automatic logic [LB-1:0] mac16(input logic [LB-1:0] acc, input logic [3:0] d);
    if (acc[LB-1:LB-4] != 4'd0) mac16 = LEN_MAX;
    else mac16 = {acc[LB-5:0], d};
  endfunction

  function automatic logic [31:0] to32(input logic [LB-1:0] x);
    logic [LB+31:0] t;
    t = {32'b0, x};
    to32 = t[31:0];
  endfunction

  function automatic st_t value_char(input st_t s, input logic [7:0] c);
    logic digit;
    logic skip;
    digit = (c >= 8'h30) && (c <= 8'h39);
    skip = 1'b0;
    if (s.cand == 2'd1) begin
      if (s.mpos == 5'd0) begin
        if (c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF) begin
          skip = 1'b1;
        end else begin
          s.mpos = 5'd1;
          if (c == CH_MINUS) begin
            s.flags = s.flags | F_NEG;
            skip = 1'b1;
          end else if (c == CH_PLUS) begin
            skip = 1'b1;
          end
        end
      end
      if (!skip && s.mpos == 5'd1) begin
        if (digit) s.decl = mac10(s.decl, c[3:0]);
        else s.mpos = 5'd2;
      end
    end else if (s.cand == 2'd2) begin
      if (s.mpos < CHK_TAG && c == chk_chr(s.mpos[2:0])) s.mpos = s.mpos + 5'd1;
      else s.mpos = 5'd31;
    end
    return s;
  endfunction

  function automatic st_t line_char(input st_t s, input logic [7:0] c);
    logic        digit;
    logic        blank;
    logic [19:0] v;
    logic [4:0]  h;
    digit = (c >= 8'h30) && (c <= 8'h39);
    blank = (c == CH_SP) || (c == CH_TAB);
    h = hex_dec(c);
    v = ({4'b0, s.status} << 3) + ({4'b0, s.status} << 1) + {16'b0, c[3:0]};
    case (s.phase)
      PH_PREFIX: begin
        if (s.mpos < HTTP_TAG && c == http_chr(s.mpos[2:0])) begin
          s.mpos = s.mpos + 5'd1;
          if (s.mpos == HTTP_TAG) begin
            s.phase = PH_VER;
            s.mpos = 5'd0;
          end
        end else begin
          s.phase = PH_BADLINE;
        end
      end
      PH_VER: begin
        if (digit) s.mpos[0] = 1'b1;
        else if (c == CH_DOT && !s.mpos[1]) s.mpos[1] = 1'b1;
        else if (blank && s.mpos[0]) s.phase = PH_SP;
        else s.phase = PH_BADLINE;
      end
      PH_SP: begin
        if (digit) begin
          s.phase = PH_CODE;
          s.status = {12'b0, c[3:0]};
        end else if (!blank) begin
          s.phase = PH_BADLINE;
        end
      end
      PH_CODE: begin
        if (digit) s.status = (v > 20'hffff) ? 16'hffff : v[15:0];
        else s.phase = PH_REST;
      end
      PH_NAME: begin
        if (c == CH_COLON) begin
          if (s.mpos == 5'd0) begin
            s.phase = PH_BADLINE;
          end else begin
            if (s.cand[0] && s.mpos == LEN_TAG) s.cand = 2'd1;
            else if (s.cand[1] && s.mpos == TE_TAG) s.cand = 2'd2;
            else s.cand = 2'd0;
            if ((s.flags & F_TRAIL) != 3'd0) s.cand = 2'd0;
            if (s.cand == 2'd1) s.decl = '0;
            s.flags = s.flags & ~F_NEG;
            s.mpos = 5'd0;
            s.phase = PH_WS;
          end
        end else begin
          if (!(s.mpos < LEN_TAG && c == len_chr(s.mpos[3:0]))) s.cand[0] = 1'b0;
          if (!(s.mpos < TE_TAG && c == te_chr(s.mpos))) s.cand[1] = 1'b0;
          if (s.mpos < 5'd31) s.mpos = s.mpos + 5'd1;
        end
      end
      PH_WS: begin
        if (c == CH_CR) begin
          s.phase = PH_BADLINE;
        end else if (!blank) begin
          s.phase = PH_VAL;
          s = value_char(s, c);
        end
      end
      PH_VAL: begin
        if (c == CH_CR) s.phase = PH_BADLINE;
        else s = value_char(s, c);
      end
      PH_CKSIZE: begin
        if (s.mpos == 5'd0) begin
          if (h[4]) s.remain = mac16(s.remain, h[3:0]);
          else s.mpos = 5'd1;
        end
      end
      PH_CKEND: s.phase = PH_BADLINE;
      default: ;
    endcase
    return s;
  endfunction

  function automatic step_t line_end(input st_t s, input logic hdr);
    step_t r;
    logic  bad;
    bad = 1'b0;
    r.emit = 1'b0;
    r.kind = KIND_CONTENT;
    r.value = 32'd0;
    case (s.phase)
      PH_CODE, PH_REST: begin
        s.flags = 3'd0;
        s.phase = PH_NAME;
        s.mpos = 5'd0;
        s.cand = 2'd3;
        r.emit = 1'b1;
        r.kind = KIND_STATUS;
        r.value = {16'b0, s.status};
      end
      PH_NAME: begin
        if (s.mpos != 5'd0) begin
          bad = 1'b1;
        end else if ((s.flags & F_TRAIL) != 3'd0) begin
          s.phase = PH_DONE;
          r.emit = 1'b1;
          r.kind = KIND_COMPLETE;
          r.value = to32(s.total);
        end else if (hdr) begin
          s.phase = PH_DONE;
          r.emit = 1'b1;
          r.kind = KIND_COMPLETE;
          r.value = s.len_present ? to32(s.decl) : 32'd0;
        end else if (s.len_present) begin
          s.total = '0;
          if (s.decl == '0) begin
            s.phase = PH_DONE;
            r.emit = 1'b1;
            r.kind = KIND_COMPLETE;
          end else begin
            s.remain = s.decl;
            s.phase = PH_BODY;
          end
        end else if (s.chunked) begin
          s.total = '0;
          s.phase = PH_CKSIZE;
          s.mpos = 5'd0;
          s.remain = '0;
          s.flags = 3'd0;
        end else begin
          bad = 1'b1;
        end
      end
      PH_VAL: begin
        if (s.cand == 2'd1) begin
          s.len_present = !(((s.flags & F_NEG) != 3'd0) && s.decl != '0);
          if (!s.len_present) s.decl = '0;
        end else if (s.cand == 2'd2) begin
          s.chunked = (s.mpos == CHK_TAG);
        end
        s.phase = PH_NAME;
        s.mpos = 5'd0;
        s.cand = 2'd3;
        s.flags = s.flags & F_TRAIL;
      end
      PH_CKSIZE: begin
        if (s.remain == '0) begin
          s.flags = F_TRAIL;
          s.phase = PH_NAME;
          s.mpos = 5'd0;
          s.cand = 2'd3;
        end else begin
          s.phase = PH_CKDATA;
        end
      end
      PH_CKEND: begin
        s.phase = PH_CKSIZE;
        s.mpos = 5'd0;
        s.remain = '0;
        s.flags = 3'd0;
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      s.phase = PH_DONE;
      r.emit = 1'b1;
      r.kind = KIND_BAD;
      r.value = 32'd0;
    end
    r.st = s;
    return r;
  endfunction

  st_t         st_r;
  st_t         st_nxt;
  logic        hdr_only_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [2:0]  out_kind_r;
  logic [2:0]  out_kind_nxt;
  logic [31:0] out_value_r;
  logic [31:0] out_value_nxt;
  logic        accept;
  step_t       res;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;

  always_comb begin
    st_t   s;
    step_t le;
    s = st_r;
    le = '0;
    res = '0;
    if (st_r.phase == PH_DONE) begin
      res.emit = 1'b0;
    end else if (in_stream_end) begin
      s.phase = PH_DONE;
      res.emit = 1'b1;
      res.kind = (st_r.phase == PH_TAIL) ? KIND_COMPLETE : KIND_EARLY;
      res.value = (st_r.phase == PH_TAIL) ? to32(st_r.total) : 32'd0;
    end else if (st_r.phase == PH_TAIL) begin
      s.phase = PH_DONE;
      res.emit = 1'b1;
      res.kind = KIND_COMPLETE;
      res.value = to32(st_r.total);
    end else if (st_r.phase == PH_BODY || st_r.phase == PH_CKDATA) begin
      if (s.total != LEN_MAX) s.total = s.total + LEN_ONE;
      s.remain = s.remain - LEN_ONE;
      if (s.remain == '0) begin
        if (st_r.phase == PH_BODY) begin
          s.phase = PH_TAIL;
        end else begin
          s.phase = PH_CKEND;
          s.flags = 3'd0;
        end
      end
      res.emit = 1'b1;
      res.kind = KIND_CONTENT;
      res.value = {24'b0, in_byte_in};
    end else if (((st_r.flags & F_CR) != 3'd0) && in_byte_in == CH_LF) begin
      s.flags = s.flags & ~F_CR;
      le = line_end(s, hdr_only_r);
      s = le.st;
      res.emit = le.emit;
      res.kind = le.kind;
      res.value = le.value;
    end else begin
      // a lone cr counts as an ordinary line character
      if ((st_r.flags & F_CR) != 3'd0) begin
        s.flags = s.flags & ~F_CR;
        s = line_char(s, CH_CR);
      end
      if (in_byte_in == CH_CR) s.flags = s.flags | F_CR;
      else s = line_char(s, in_byte_in);
    end
    res.st = s;
  end

  always_comb begin
    st_nxt = st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt = out_kind_r;
    out_value_nxt = out_value_r;
    if (accept) begin
      st_nxt = res.st;
      if (res.emit) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt = res.kind;
        out_value_nxt = res.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase <= PH_PREFIX;
      st_r.mpos <= 5'd0;
      st_r.cand <= 2'd3;
      st_r.flags <= 3'd0;
      st_r.status <= 16'd0;
      st_r.decl <= '0;
      st_r.len_present <= 1'b0;
      st_r.chunked <= 1'b0;
      st_r.remain <= '0;
      st_r.total <= '0;
      hdr_only_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) hdr_only_r <= cfg_no_body;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_value_r <= out_value_nxt;
  end

`ifndef ASSERT_OFF
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_DONE |=> st_r.phase == PH_DONE)
    else $error("parser left the done phase");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no pending result");

  a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res.emit && res.kind != KIND_CONTENT && res.kind != KIND_STATUS)
      |=> st_r.phase == PH_DONE)
    else $error("final result without entering done");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_kind_r <= KIND_EARLY)
    else $error("result kind out of range");
`endif

endmodule
`default_nettype wire
